// ----- rtl/oim_pkg.sv -----
package oim_pkg;

  // generation tag kept with every table entry; zero is never a live tag
  localparam int GEN_W = 4;

  // request kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_X_ORIGIN = 2'd2;
  localparam logic [1:0] CFG_Y_ORIGIN = 2'd3;

  localparam logic [8:0]  WIDTH_RESET  = 9'd256;
  localparam logic [8:0]  HEIGHT_RESET = 9'd256;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] col;
    logic [7:0] row;
  } req_t;

  typedef struct packed {
    logic        is_inside;
    logic        out_of_range;
    logic [16:0] grid_x;
    logic [16:0] grid_y;
  } rsp_t;

  // one row or column span: tag, first and last edge position
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [7:0]       first;
    logic [7:0]       last;
  } entry_t;

  // result of looking at one span for one position
  typedef struct packed {
    entry_t upd;
    logic   covers;
  } span_t;

  typedef enum logic {
    ST_RUN,
    ST_SWEEP
  } state_t;

endpackage

// ----- rtl/oim_table.sv -----
module oim_table import oim_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t mem_q;
  entry_t fwd_data;
  logic   fwd_hit;

  // synchronous write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // synchronous read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // capture a write that lands on the edge of the read to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

// ----- rtl/oim_span.sv -----
module oim_span import oim_pkg::*; (
  input  entry_t           cur,
  input  logic [GEN_W-1:0] live_gen,
  input  logic [7:0]       pos,
  output span_t            span
);

  logic live;

  // an entry counts only when its tag matches the current generation
  assign live = (cur.gen == live_gen);

  // widened span after marking pos, and coverage test for a query at pos
  always_comb begin
    span.upd.gen = live_gen;
    if (!live) begin
      span.upd.first = pos;
      span.upd.last  = pos;
    end else begin
      span.upd.first = (pos < cur.first) ? pos : cur.first;
      span.upd.last  = (pos > cur.last) ? pos : cur.last;
    end
    span.covers = live && (cur.first <= pos) && (pos <= cur.last);
  end

endmodule

// ----- rtl/outline_interior_mask_unit.sv -----
// channel   dir  handshake            payload
// request   in   req_valid/req_ready  req   (kind, col, row)
// response  out  rsp_valid/rsp_ready  rsp   (is_inside, out_of_range, grid_x, grid_y)
// config    in   cfg_we               cfg_index, cfg_data
//
// one request per cycle while no sweep runs or starts and stage one can advance; a
// taken query passes stage one, then the response register; row and column spans
// sit in two memories with a synchronous read, updated by read-modify-write;
// back-to-back touches of one entry use a forwarded copy; clear bumps a
// generation tag; when it wraps, and after reset, a sweep retags every entry
// a held response stalls the request side only when a query waits behind it
module outline_interior_mask_unit import oim_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ROW_AW = $clog2(MAX_HEIGHT);
  localparam int COL_AW = $clog2(MAX_WIDTH);
  localparam int SWEEP_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CNT_W = $clog2(SWEEP_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SWEEP_DEPTH - 1);
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  // configuration registers
  logic [8:0]  width_in_use;
  logic [8:0]  height_in_use;
  logic [15:0] x_origin;
  logic [15:0] y_origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= WIDTH_RESET;
      height_in_use <= HEIGHT_RESET;
      x_origin      <= '0;
      y_origin      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:    width_in_use  <= cfg_data[8:0];
        CFG_HEIGHT:   height_in_use <= cfg_data[8:0];
        CFG_X_ORIGIN: x_origin      <= cfg_data;
        CFG_Y_ORIGIN: y_origin      <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [GEN_W-1:0] cur_gen;

  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_col;
  logic [7:0] s1_row;
  logic       s1_in_range;
  logic       s1_advance;
  logic       sweep_start;
  logic       req_fire;

  entry_t row_rd;
  entry_t col_rd;
  entry_t row_wr_data;
  entry_t col_wr_data;
  logic   row_wr_en;
  logic   col_wr_en;
  logic [ROW_AW-1:0] row_wr_addr;
  logic [COL_AW-1:0] col_wr_addr;
  span_t  row_span;
  span_t  col_span;

  // handshake and stage control
  assign sweep_start = s1_valid && (s1_kind == KIND_CLEAR) && (cur_gen == GEN_MAX);
  assign s1_advance  = s1_valid && ((s1_kind != KIND_QUERY) || !rsp_valid || rsp_ready);
  assign req_ready   = (state == ST_RUN) && !sweep_start && (!s1_valid || s1_advance);
  assign req_fire    = req_valid && req_ready;

  // stage one holds the request while its table entries are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_kind <= req.kind;
      s1_col  <= req.col;
      s1_row  <= req.row;
    end
  end

  // usable size is the register limited by the table depth
  assign s1_in_range = ({1'b0, s1_col} < width_in_use) && (32'(s1_col) < MAX_WIDTH) &&
                       ({1'b0, s1_row} < height_in_use) && (32'(s1_row) < MAX_HEIGHT);

  // sweep state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_RUN: begin
        if (sweep_start) begin
          state_next = ST_SWEEP;
          cnt_next   = '0;
        end
      end
      ST_SWEEP: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_RUN;
        cnt_next   = '0;
      end
    endcase
  end

  // generation tag, advanced by clear
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gen <= GEN_FIRST;
    end else if (s1_valid && (s1_kind == KIND_CLEAR)) begin
      cur_gen <= (cur_gen == GEN_MAX) ? GEN_FIRST : cur_gen + 1'b1;
    end
  end

  // span update and coverage for the row and the column
  oim_span u_row_span (
    .cur      (row_rd),
    .live_gen (cur_gen),
    .pos      (s1_col),
    .span     (row_span)
  );

  oim_span u_col_span (
    .cur      (col_rd),
    .live_gen (cur_gen),
    .pos      (s1_row),
    .span     (col_span)
  );

  // write back a mark, or retag an entry during the sweep
  always_comb begin
    if (state == ST_SWEEP) begin
      row_wr_en   = 32'(cnt) < MAX_HEIGHT;
      col_wr_en   = 32'(cnt) < MAX_WIDTH;
      row_wr_addr = ROW_AW'(cnt);
      col_wr_addr = COL_AW'(cnt);
      row_wr_data = '0;
      col_wr_data = '0;
    end else begin
      row_wr_en   = s1_valid && (s1_kind == KIND_MARK) && s1_in_range;
      col_wr_en   = row_wr_en;
      row_wr_addr = ROW_AW'(s1_row);
      col_wr_addr = COL_AW'(s1_col);
      row_wr_data = row_span.upd;
      col_wr_data = col_span.upd;
    end
  end

  oim_table #(.DEPTH(MAX_HEIGHT)) u_row_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_fire),
    .rd_addr (ROW_AW'(req.row)),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_data (row_rd)
  );

  oim_table #(.DEPTH(MAX_WIDTH)) u_col_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_fire),
    .rd_addr (COL_AW'(req.col)),
    .wr_en   (col_wr_en),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_data (col_rd)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance && (s1_kind == KIND_QUERY)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && (s1_kind == KIND_QUERY)) begin
      rsp.is_inside    <= s1_in_range && row_span.covers && col_span.covers;
      rsp.out_of_range <= !s1_in_range;
      rsp.grid_x       <= 17'(s1_col) + 17'(x_origin);
      rsp.grid_y       <= 17'(s1_row) + 17'(y_origin);
    end
  end

`ifndef SYNTHESIS
  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !req_ready)
    else $error("request taken during sweep");

  a_rsp_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(s1_valid && (s1_kind == KIND_QUERY)))
    else $error("response without a query");

  a_mark_writes: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_kind == KIND_MARK) && s1_in_range) |-> (row_wr_en && col_wr_en))
    else $error("mark not written back");

  a_clear_bumps_gen: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_kind == KIND_CLEAR) && (cur_gen != GEN_MAX))
      |=> (cur_gen == GEN_W'($past(cur_gen) + 1'b1)))
    else $error("clear did not advance generation");
`endif

endmodule
